>>> rtl/sha1_byte_stream_hasher_assert.svh
// Assertion macros shared by the SHA-1 byte stream hasher RTL.
// Each macro expands to one labeled concurrent assertion clocked on the given clock.
`ifndef SHA1_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA1_BYTE_STREAM_HASHER_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define SBH_ASSERT_NOW(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("sha1 hasher: invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define SBH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sha1 hasher: same-cycle implication violated");

// The consequent holds in the cycle after the antecedent.
`define SBH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sha1 hasher: next-cycle implication violated");

`endif

>>> rtl/sha1bsh_pkg.sv
// Types and constants of the SHA-1 byte stream hasher.
// Used by sha1bsh_round and sha1_byte_stream_hasher; depends on nothing else.
package sha1bsh_pkg;

	localparam int ROUND_W = 7;
	typedef logic [ROUND_W-1:0] round_t;

	localparam round_t ROUNDS      = 7'd80;
	localparam round_t ROUND_LAST  = 7'd79;
	localparam round_t ROUND_PH2   = 7'd20;
	localparam round_t ROUND_PH3   = 7'd40;
	localparam round_t ROUND_PH4   = 7'd60;

	localparam logic [31:0] K_PH1 = 32'h5A827999;
	localparam logic [31:0] K_PH2 = 32'h6ED9EBA1;
	localparam logic [31:0] K_PH3 = 32'h8F1BBCDC;
	localparam logic [31:0] K_PH4 = 32'hCA62C1D6;

	localparam logic [31:0] H_INIT [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	// Byte offset where the 64-bit length starts (448 bits), and the last byte (504 bits).
	localparam logic [5:0] LEN_OFFSET = 6'd56;
	localparam logic [5:0] BLOCK_LAST = 6'd63;

	localparam logic [7:0] PAD_MARK_BYTE = 8'h80;

	localparam logic [1:0] OP_ABSORB      = 2'd0;
	localparam logic [1:0] OP_ABSORB_FIN  = 2'd1;
	localparam logic [1:0] OP_FINISH      = 2'd2;
	localparam logic [1:0] OP_UNUSED      = 2'd3;

	localparam logic [2:0] WORD_LAST = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		PAD_MARK,
		PAD_ZERO,
		PAD_LEN,
		PAD_DONE
	} pad_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} work_t;

endpackage

>>> rtl/sha1bsh_round.sv
// One SHA-1 round and one message schedule step, purely combinational.
// Depends on sha1bsh_pkg for the working-variable struct and round constants.
module sha1bsh_round import sha1bsh_pkg::*; (
	input  work_t       cur,
	input  round_t      round,
	input  logic [31:0] w0,
	input  logic [31:0] w2,
	input  logic [31:0] w8,
	input  logic [31:0] w13,
	output work_t       nxt,
	output logic [31:0] sched
);

	logic [31:0] f;
	logic [31:0] k;
	logic [31:0] mix;

	always_comb begin
		if (round < ROUND_PH2) begin
			f = (cur.b & cur.c) | (~cur.b & cur.d);
			k = K_PH1;
		end else if (round < ROUND_PH3) begin
			f = cur.b ^ cur.c ^ cur.d;
			k = K_PH2;
		end else if (round < ROUND_PH4) begin
			f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
			k = K_PH3;
		end else begin
			f = cur.b ^ cur.c ^ cur.d;
			k = K_PH4;
		end
	end

	always_comb begin
		nxt.a = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w0;
		nxt.b = cur.a;
		nxt.c = {cur.b[1:0], cur.b[31:2]};
		nxt.d = cur.c;
		nxt.e = cur.d;
	end

	// The window holds w[t..t+15]; this produces w[t+16].
	assign mix   = w13 ^ w8 ^ w2 ^ w0;
	assign sched = {mix[30:0], mix[31]};

endmodule

>>> rtl/sha1_byte_stream_hasher.sv
// SHA-1 byte stream hasher: absorbs one byte per word and emits a 160-bit digest as five words.
// A byte that fills a block starts a compression: 80 rounds, then the chaining add.
// A finish feeds 9 to 72 pad bytes at one per cycle, runs one or two compressions, then
// presents five digest words. The round unit, used once per cycle, sets the block rate.
// Reset (arst_n low, asynchronous) loads the initial chaining values and clears length and state.
// Depends on sha1bsh_pkg, sha1bsh_round and sha1_byte_stream_hasher_assert.svh.
`include "sha1_byte_stream_hasher_assert.svh"

module sha1_byte_stream_hasher import sha1bsh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] digest_word
	output logic [2:0]  m_axis_tuser,   // [2:0] word_index
	output logic        m_axis_tlast    // last_word
);

	// Control state.
	state_t      state_q, state_nxt;
	pad_t        pad_kind_q;
	logic        finishing_q;
	logic [5:0]  byte_pos_q;
	logic [63:0] bit_len_q;
	round_t      round_q;
	logic [2:0]  out_idx_q;
	logic [31:0] chain_q [5];

	// Datapath registers; they need no reset since every value is written before use.
	work_t       work_q;
	logic [31:0] acc_q;
	logic [31:0] win_q [16];

	// Decoded controls.
	logic        in_fire;
	logic        out_fire;
	logic        byte_we;
	logic        absorb;
	logic [7:0]  byte_val;
	logic [5:0]  pos_nxt;
	logic        block_full;
	logic        round_en;
	logic        add_en;
	logic [31:0] packed_word;
	pad_t        pad_kind_nxt;

	work_t       round_nxt;
	logic [31:0] sched;

	sha1bsh_round u_round (
		.cur   (work_q),
		.round (round_q),
		.w0    (win_q[0]),
		.w2    (win_q[2]),
		.w8    (win_q[8]),
		.w13   (win_q[13]),
		.nxt   (round_nxt),
		.sched (sched)
	);

	// The handshake signals come straight from the state register: input is taken only
	// when idle, and a digest word is shown only while the output state is held.
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = chain_q[out_idx_q];
	assign m_axis_tuser  = out_idx_q;
	assign m_axis_tlast  = (out_idx_q == WORD_LAST);

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	// Control decode: which byte goes into the packer this cycle, and whether a round or the add runs.
	always_comb begin
		absorb   = 1'b0;
		byte_we  = 1'b0;
		byte_val = s_axis_tdata;
		round_en = 1'b0;
		add_en   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				absorb  = in_fire &&
					(s_axis_tuser == OP_ABSORB || s_axis_tuser == OP_ABSORB_FIN);
				byte_we = absorb;
			end
			ST_PAD: begin
				byte_we = 1'b1;
				case (pad_kind_q)
					PAD_MARK: byte_val = PAD_MARK_BYTE;
					PAD_LEN:  byte_val = bit_len_q[{~byte_pos_q[2:0], 3'b000} +: 8];
					default:  byte_val = '0;
				endcase
			end
			ST_ROUND: round_en = 1'b1;
			ST_ADD:   add_en = 1'b1;
			ST_OUT: ;
			default: ;
		endcase
	end

	assign pos_nxt     = byte_pos_q + 6'd1;
	assign block_full  = byte_we && (byte_pos_q == BLOCK_LAST);
	assign packed_word = {acc_q[23:0], byte_val};

	// The padding walks from the marker byte through zeros to the eight length bytes.
	always_comb begin
		pad_kind_nxt = pad_kind_q;
		case (pad_kind_q) inside
			PAD_MARK, PAD_ZERO: begin
				if (pos_nxt == LEN_OFFSET) begin
					pad_kind_nxt = PAD_LEN;
				end else begin
					pad_kind_nxt = PAD_ZERO;
				end
			end
			PAD_LEN: begin
				if (pos_nxt == '0) begin
					pad_kind_nxt = PAD_DONE;
				end
			end
			default: ;
		endcase
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (block_full) begin
						state_nxt = ST_ROUND;
					end else if (s_axis_tuser == OP_ABSORB_FIN || s_axis_tuser == OP_FINISH) begin
						state_nxt = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (block_full) begin
					state_nxt = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (round_q == ROUND_LAST) begin
					state_nxt = ST_ADD;
				end
			end
			ST_ADD: begin
				if (!finishing_q) begin
					state_nxt = ST_IDLE;
				end else if (pad_kind_q == PAD_DONE) begin
					state_nxt = ST_OUT;
				end else begin
					state_nxt = ST_PAD;
				end
			end
			ST_OUT: begin
				if (out_fire && m_axis_tlast) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pad_kind_q  <= PAD_MARK;
			finishing_q <= 1'b0;
			byte_pos_q  <= '0;
			bit_len_q   <= '0;
			round_q     <= '0;
			out_idx_q   <= '0;
			for (int i = 0; i < 5; i++) begin
				chain_q[i] <= H_INIT[i];
			end
		end else begin
			state_q <= state_nxt;
			if (in_fire && (s_axis_tuser == OP_ABSORB_FIN || s_axis_tuser == OP_FINISH)) begin
				finishing_q <= 1'b1;
				pad_kind_q  <= PAD_MARK;
			end
			if (absorb) begin
				bit_len_q <= bit_len_q + 64'd8;
			end
			if (state_q == ST_PAD) begin
				pad_kind_q <= pad_kind_nxt;
			end
			if (byte_we) begin
				byte_pos_q <= pos_nxt;
			end
			if (block_full) begin
				round_q <= '0;
			end else if (round_en) begin
				round_q <= round_q + 7'd1;
			end
			if (add_en) begin
				chain_q[0] <= chain_q[0] + work_q.a;
				chain_q[1] <= chain_q[1] + work_q.b;
				chain_q[2] <= chain_q[2] + work_q.c;
				chain_q[3] <= chain_q[3] + work_q.d;
				chain_q[4] <= chain_q[4] + work_q.e;
			end
			if (out_fire) begin
				if (m_axis_tlast) begin
					// Digest delivered: start the next message from the initial values.
					out_idx_q   <= '0;
					finishing_q <= 1'b0;
					pad_kind_q  <= PAD_MARK;
					bit_len_q   <= '0;
					byte_pos_q  <= '0;
					for (int i = 0; i < 5; i++) begin
						chain_q[i] <= H_INIT[i];
					end
				end else begin
					out_idx_q <= out_idx_q + 3'd1;
				end
			end
		end
	end

	// Datapath registers. Bytes are packed big-endian into a word accumulator, and each
	// full word shifts into the sixteen-word window; during rounds the window shifts in
	// the schedule words, so its head is always the word for the current round.
	always_ff @(posedge clk) begin
		if (byte_we) begin
			acc_q <= packed_word;
		end
		if (byte_we && (byte_pos_q[1:0] == 2'd3)) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= packed_word;
		end else if (round_en) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= sched;
		end
		if (block_full) begin
			work_q.a <= chain_q[0];
			work_q.b <= chain_q[1];
			work_q.c <= chain_q[2];
			work_q.d <= chain_q[3];
			work_q.e <= chain_q[4];
		end else if (round_en) begin
			work_q <= round_nxt;
		end
	end

	// Input and output sides are never open in the same cycle.
	`SBH_ASSERT_NOW(a_sides_exclusive, clk, arst_n, !(s_axis_tready && m_axis_tvalid))

	// A digest is shown only once the final block, length included, has been compressed.
	`SBH_ASSERT_IMPL(a_out_after_pad, clk, arst_n, m_axis_tvalid,
		(byte_pos_q == '0) && (pad_kind_q == PAD_DONE))

	// The round counter stays inside the 80 rounds while compressing.
	`SBH_ASSERT_IMPL(a_round_range, clk, arst_n, state_q == ST_ROUND, round_q < ROUNDS)

	// The last round is always followed by the chaining add.
	`SBH_ASSERT_NEXT(a_round_to_add, clk, arst_n,
		(state_q == ST_ROUND) && (round_q == ROUND_LAST), state_q == ST_ADD)

	// Taking the last digest word reopens the input with a cleared length.
	`SBH_ASSERT_NEXT(a_restart, clk, arst_n, out_fire && m_axis_tlast,
		s_axis_tready && (bit_len_q == '0) && (out_idx_q == '0))

endmodule
